FILE: rtl/sshit_pkg.sv
// ----------------------------------------------------------------------------
// Swept segment sphere hit test package
// Widths, reset constants and the item record that travels down the pipeline.
// ----------------------------------------------------------------------------
package sshit_pkg;

   localparam int POS_W         = 32;          // Q16.16 positions, velocities
   localparam int STEP_W        = 16;          // unsigned Q0.16 scaled step
   localparam int WIDE_W        = POS_W + 1;   // previous position
   localparam int DIFF_W        = POS_W + 2;   // target minus previous, closest
   localparam int LEN2_W        = 64;          // squared segment length
   localparam int DOT_W         = 68;          // exact dot product
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [STEP_W-1:0] SCALED_STEP_RESET = 16'd1092;

   typedef struct packed {
      logic [2:0][WIDE_W-1:0] prev;
      logic [2:0][POS_W-1:0]  seg;
      logic [2:0][POS_W-1:0]  tgt;
      logic [POS_W-1:0]       radius;
      logic                   skip;
   } geom_type;

endpackage

FILE: rtl/sshit_front.sv
// ----------------------------------------------------------------------------
// Swept segment front end
// Builds the segment, the previous position, its squared length and the dot
// product with the target offset over four register stages.
// ----------------------------------------------------------------------------
module sshit_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   valid_in,
   input  logic [sshit_pkg::STEP_W-1:0]           scaled_step,
   input  logic [2:0][sshit_pkg::POS_W-1:0]       proj,
   input  logic [2:0][sshit_pkg::POS_W-1:0]       vel,
   input  logic [2:0][sshit_pkg::POS_W-1:0]       tgt,
   input  logic [sshit_pkg::POS_W-1:0]            radius,
   input  logic                                   skip,
   output logic                                   valid_out,
   output sshit_pkg::geom_type                    geom_out,
   output logic [sshit_pkg::LEN2_W-1:0]           len2_out,
   output logic signed [sshit_pkg::DOT_W-1:0]     dot_out
);

   localparam int POS_W  = sshit_pkg::POS_W;
   localparam int STEP_W = sshit_pkg::STEP_W;
   localparam int PROD_W = POS_W + STEP_W + 1;
   localparam int WIDE_W = sshit_pkg::WIDE_W;
   localparam int DIFF_W = sshit_pkg::DIFF_W;
   localparam int SQ_W   = 2 * POS_W;
   localparam int DP_W   = DIFF_W + POS_W;
   localparam int DOT_W  = sshit_pkg::DOT_W;

   // Stage 1: segment per axis.
   logic                    v1_ff;
   logic [2:0][POS_W-1:0]   seg1_in, seg1_ff, p1_ff, t1_ff;
   logic [POS_W-1:0]        r1_ff;
   logic                    s1_ff;
   logic signed [PROD_W-1:0] vprod [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vprod[i]   = $signed(vel[i]) * $signed({1'b0, scaled_step});
         seg1_in[i] = vprod[i][POS_W+STEP_W-1:STEP_W];
      end
   end

   // Stage 2: previous position and target offset.
   logic                     v2_ff;
   sshit_pkg::geom_type      g2_in, g2_ff;
   logic [2:0][DIFF_W-1:0]   tos2_in, tos2_ff;

   always_comb begin
      g2_in.seg    = seg1_ff;
      g2_in.tgt    = t1_ff;
      g2_in.radius = r1_ff;
      g2_in.skip   = s1_ff;
      for (int i = 0; i < 3; i++) begin
         g2_in.prev[i] = WIDE_W'($signed(p1_ff[i])) - WIDE_W'($signed(seg1_ff[i]));
         tos2_in[i]    = DIFF_W'($signed(t1_ff[i])) - DIFF_W'($signed(g2_in.prev[i]));
      end
   end

   // Stage 3: squares and dot product terms.
   logic                  v3_ff;
   sshit_pkg::geom_type   g3_ff;
   logic [SQ_W-1:0]       sq3_in [3];
   logic [SQ_W-1:0]       sq3_ff [3];
   logic signed [DP_W-1:0] dp3_in [3];
   logic signed [DP_W-1:0] dp3_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq3_in[i] = SQ_W'($signed(g2_ff.seg[i]) * $signed(g2_ff.seg[i]));
         dp3_in[i] = $signed(tos2_ff[i]) * $signed(g2_ff.seg[i]);
      end
   end

   // Stage 4: sums.
   logic [sshit_pkg::LEN2_W-1:0] len2_in;
   logic signed [DOT_W-1:0]      dot_in;

   assign len2_in = sshit_pkg::LEN2_W'(sq3_ff[0]) + sshit_pkg::LEN2_W'(sq3_ff[1])
                  + sshit_pkg::LEN2_W'(sq3_ff[2]);
   assign dot_in  = DOT_W'(dp3_ff[0]) + DOT_W'(dp3_ff[1]) + DOT_W'(dp3_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         valid_out <= 1'b0;
      end else if (adv) begin
         v1_ff     <= valid_in;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         valid_out <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg1_ff  <= seg1_in;
         p1_ff    <= proj;
         t1_ff    <= tgt;
         r1_ff    <= radius;
         s1_ff    <= skip;
         g2_ff    <= g2_in;
         tos2_ff  <= tos2_in;
         g3_ff    <= g2_ff;
         sq3_ff   <= sq3_in;
         dp3_ff   <= dp3_in;
         geom_out <= g3_ff;
         len2_out <= len2_in;
         dot_out  <= dot_in;
      end
   end

endmodule

FILE: rtl/sshit_divider.sv
// ----------------------------------------------------------------------------
// Segment parameter divider
// Clamped t = dot / len2 by restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sshit_divider #(
   parameter int FRAC_BITS = sshit_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                valid_in,
   input  sshit_pkg::geom_type                 geom_in,
   input  logic [sshit_pkg::LEN2_W-1:0]        len2_in,
   input  logic signed [sshit_pkg::DOT_W-1:0]  dot_in,
   output logic                                valid_out,
   output sshit_pkg::geom_type                 geom_out,
   output logic [FRAC_BITS:0]                  t_out
);

   localparam int LEN2_W = sshit_pkg::LEN2_W;
   localparam int DOT_W  = sshit_pkg::DOT_W;
   localparam logic [LEN2_W-1:0] LEN2_EPS =
      LEN2_W'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);
   localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic                  v_ff    [FRAC_BITS+1];
   sshit_pkg::geom_type   g_ff    [FRAC_BITS+1];
   logic [LEN2_W-1:0]     len2_ff [FRAC_BITS+1];
   logic [LEN2_W-1:0]     rem_ff  [FRAC_BITS+1];
   logic [FRAC_BITS-1:0]  q_ff    [FRAC_BITS+1];
   logic                  fix_ff  [FRAC_BITS+1];
   logic [FRAC_BITS:0]    tfix_ff [FRAC_BITS+1];

   // Setup stage: degenerate segment, non-positive dot and full clamp are settled here.
   logic small_len, non_pos, clamp_one;

   assign small_len = len2_in <= LEN2_EPS;
   assign non_pos   = dot_in[DOT_W-1] || (dot_in == '0);
   assign clamp_one = (|dot_in[DOT_W-1:LEN2_W]) || (dot_in[LEN2_W-1:0] >= len2_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff[0]    <= geom_in;
         len2_ff[0] <= len2_in;
         rem_ff[0]  <= dot_in[LEN2_W-1:0];
         q_ff[0]    <= '0;
         fix_ff[0]  <= small_len || non_pos || clamp_one;
         tfix_ff[0] <= (!small_len && !non_pos && clamp_one) ? T_ONE : '0;
      end
   end

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
      logic [LEN2_W:0]   shifted;
      logic              take;
      logic [LEN2_W-1:0] rem_in;

      assign shifted = {rem_ff[k-1], 1'b0};
      assign take    = shifted >= {1'b0, len2_ff[k-1]};
      assign rem_in  = take ? LEN2_W'(shifted - {1'b0, len2_ff[k-1]})
                            : shifted[LEN2_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            g_ff[k]    <= g_ff[k-1];
            len2_ff[k] <= len2_ff[k-1];
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= {q_ff[k-1][FRAC_BITS-2:0], take};
            fix_ff[k]  <= fix_ff[k-1];
            tfix_ff[k] <= tfix_ff[k-1];
         end
      end
   end

   assign valid_out = v_ff[FRAC_BITS];
   assign geom_out  = g_ff[FRAC_BITS];
   assign t_out     = fix_ff[FRAC_BITS] ? tfix_ff[FRAC_BITS] : {1'b0, q_ff[FRAC_BITS]};

endmodule

FILE: rtl/sshit_back.sv
// ----------------------------------------------------------------------------
// Closest point and distance test
// Places the closest point, squares its distance to the center and compares
// against the squared radius; the last stage is the result register.
// ----------------------------------------------------------------------------
module sshit_back #(
   parameter int FRAC_BITS = sshit_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                valid_in,
   input  sshit_pkg::geom_type                 geom_in,
   input  logic [FRAC_BITS:0]                  t_in,
   output logic                                valid_out,
   output logic                                hit_out,
   output logic [2:0][sshit_pkg::POS_W-1:0]    closest_out
);

   localparam int POS_W  = sshit_pkg::POS_W;
   localparam int DIFF_W = sshit_pkg::DIFF_W;
   localparam int OFF_W  = POS_W + FRAC_BITS + 2;
   localparam int MAG_W  = POS_W - 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = 2 * POS_W;
   localparam logic signed [DIFF_W-1:0] MAG_MAX = DIFF_W'((64'd1 << (POS_W - 1)) - 64'd1);
   localparam logic signed [DIFF_W-1:0] POS_MIN = -(MAG_MAX + DIFF_W'(1));

   // Stage 1: offset along the segment.
   logic                    v1_ff;
   sshit_pkg::geom_type     g1_ff;
   logic signed [OFF_W-1:0] off1_in [3];
   logic signed [OFF_W-1:0] off1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off1_in[i] = $signed(geom_in.seg[i]) * $signed({1'b0, t_in});
      end
   end

   // Stage 2: closest point and its distance to the center per axis.
   logic                    v2_ff;
   logic signed [OFF_W-1:0] off_sh [3];
   logic signed [DIFF_W-1:0] cl2_in [3];
   logic signed [DIFF_W-1:0] cl2_ff [3];
   logic signed [DIFF_W-1:0] d2 [3];
   logic [MAG_W-1:0]        mag2_in [3];
   logic [MAG_W-1:0]        mag2_ff [3];
   logic                    far2_in, far2_ff;
   logic [POS_W-1:0]        r2_ff;
   logic                    s2_ff;

   always_comb begin
      far2_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         off_sh[i]  = off1_ff[i] >>> FRAC_BITS;
         cl2_in[i]  = DIFF_W'($signed(g1_ff.prev[i])) + off_sh[i][DIFF_W-1:0];
         d2[i]      = DIFF_W'($signed(g1_ff.tgt[i])) - cl2_in[i];
         mag2_in[i] = d2[i][DIFF_W-1] ? MAG_W'(-d2[i]) : d2[i][MAG_W-1:0];
         if ((d2[i] > MAG_MAX) || (d2[i] < -MAG_MAX)) begin
            far2_in = 1'b1;
         end
      end
   end

   // Stage 3: squares and saturated closest point.
   logic                     v3_ff;
   logic [SQ_W-1:0]          sq3_ff [3];
   logic [SUM_W-1:0]         rad3_in, rad3_ff;
   logic                     live3_ff;
   logic [2:0][POS_W-1:0]    sat3_in, sat3_ff;

   assign rad3_in = SUM_W'($signed(r2_ff) * $signed(r2_ff));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         priority if (cl2_ff[i] > MAG_MAX) begin
            sat3_in[i] = MAG_MAX[POS_W-1:0];
         end else if (cl2_ff[i] < POS_MIN) begin
            sat3_in[i] = POS_MIN[POS_W-1:0];
         end else begin
            sat3_in[i] = cl2_ff[i][POS_W-1:0];
         end
      end
   end

   // Stage 4: distance sum and compare into the result register.
   logic [SUM_W-1:0] dist2;

   assign dist2 = SUM_W'(sq3_ff[0]) + SUM_W'(sq3_ff[1]) + SUM_W'(sq3_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         valid_out <= 1'b0;
      end else if (adv) begin
         v1_ff     <= valid_in;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         valid_out <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_ff   <= geom_in;
         off1_ff <= off1_in;
         cl2_ff  <= cl2_in;
         mag2_ff <= mag2_in;
         far2_ff <= far2_in;
         r2_ff   <= g1_ff.radius;
         s2_ff   <= g1_ff.skip;
         for (int i = 0; i < 3; i++) begin
            sq3_ff[i] <= mag2_ff[i] * mag2_ff[i];
         end
         rad3_ff  <= rad3_in;
         live3_ff <= !far2_ff && !s2_ff && !r2_ff[POS_W-1] && (r2_ff != '0);
         sat3_ff  <= sat3_in;
         hit_out     <= live3_ff && (dist2 < rad3_ff);
         closest_out <= sat3_ff;
      end
   end

endmodule

FILE: rtl/swept_segment_sphere_hit_test.sv
// ----------------------------------------------------------------------------
// Swept segment sphere hit test
// Tests the segment a projectile swept during the last frame against a target
// sphere and reports the hit flag and the closest point on the segment.
//
//   channel  | ports        | direction | content
//   ---------+--------------+-----------+------------------------------------
//   request  | req_*        | in        | projectile, velocity, sphere, skip
//   response | rsp_*        | out       | hit flag, closest point
//   config   | csr_wr_*     | in        | scaled step, written at once
//
// A beat enters every cycle unless the pipeline holds; the divider resolves one
// bit of t per stage.
// Reset is synchronous and empties the pipeline; scaled step returns to 1092.
// When the result register holds a beat that is not taken, the whole pipeline
// holds and req_ready drops.
// ----------------------------------------------------------------------------
module swept_segment_sphere_hit_test #(
   parameter int FRAC_BITS = sshit_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sshit_pkg::POS_W-1:0] req_proj_x,
   input  logic signed [sshit_pkg::POS_W-1:0] req_proj_y,
   input  logic signed [sshit_pkg::POS_W-1:0] req_proj_z,
   input  logic signed [sshit_pkg::POS_W-1:0] req_vel_x,
   input  logic signed [sshit_pkg::POS_W-1:0] req_vel_y,
   input  logic signed [sshit_pkg::POS_W-1:0] req_vel_z,
   input  logic signed [sshit_pkg::POS_W-1:0] req_target_x,
   input  logic signed [sshit_pkg::POS_W-1:0] req_target_y,
   input  logic signed [sshit_pkg::POS_W-1:0] req_target_z,
   input  logic signed [sshit_pkg::POS_W-1:0] req_hit_radius,
   input  logic                              req_skip_target,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic signed [sshit_pkg::POS_W-1:0] rsp_closest_x,
   output logic signed [sshit_pkg::POS_W-1:0] rsp_closest_y,
   output logic signed [sshit_pkg::POS_W-1:0] rsp_closest_z,
   input  logic                              csr_wr_en,
   input  logic [sshit_pkg::STEP_W-1:0]      csr_wr_data
);

   logic [sshit_pkg::STEP_W-1:0] step_ff;
   logic                         adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= sshit_pkg::SCALED_STEP_RESET;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic                                fr_valid;
   sshit_pkg::geom_type                 fr_geom;
   logic [sshit_pkg::LEN2_W-1:0]        fr_len2;
   logic signed [sshit_pkg::DOT_W-1:0]  fr_dot;
   logic                                div_valid;
   sshit_pkg::geom_type                 div_geom;
   logic [FRAC_BITS:0]                  div_t;
   logic [2:0][sshit_pkg::POS_W-1:0]    closest;

   sshit_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .valid_in    (req_valid && req_ready),
      .scaled_step (step_ff),
      .proj        ({req_proj_z, req_proj_y, req_proj_x}),
      .vel         ({req_vel_z, req_vel_y, req_vel_x}),
      .tgt         ({req_target_z, req_target_y, req_target_x}),
      .radius      (req_hit_radius),
      .skip        (req_skip_target),
      .valid_out   (fr_valid),
      .geom_out    (fr_geom),
      .len2_out    (fr_len2),
      .dot_out     (fr_dot)
   );

   sshit_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_in  (fr_valid),
      .geom_in   (fr_geom),
      .len2_in   (fr_len2),
      .dot_in    (fr_dot),
      .valid_out (div_valid),
      .geom_out  (div_geom),
      .t_out     (div_t)
   );

   sshit_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .valid_in    (div_valid),
      .geom_in     (div_geom),
      .t_in        (div_t),
      .valid_out   (rsp_valid),
      .hit_out     (rsp_hit),
      .closest_out (closest)
   );

   assign rsp_closest_x = closest[0];
   assign rsp_closest_y = closest[1];
   assign rsp_closest_z = closest[2];

`ifndef SYNTHESIS
   // The parameter along the segment never goes past one.
   a_t_bounded: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (div_t <= ((FRAC_BITS + 1)'(1) << FRAC_BITS)))
      else $error("segment parameter above one");

   // A held pipeline keeps the divider output in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(div_t) && $stable(div_valid)))
      else $error("divider output moved during a stall");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");
`endif

endmodule
